// File: rtl/core/kvte_pkg.sv
package kvte_pkg;

  localparam int unsigned CAPACITY    = 256;
  localparam int unsigned KEY_WIDTH   = 32;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned ADDR_W      = $clog2(CAPACITY);
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);
  localparam int unsigned ENTRY_W     = KEY_WIDTH + VALUE_WIDTH;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned LIMIT_W     = 9;
  localparam int unsigned STEP_W      = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);
  localparam logic [CNT_W-1:0]   CAP_CNT     = CNT_W'(CAPACITY);

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UPSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd4;
  localparam logic [CMD_W-1:0] CMD_GETIDX = 3'd5;

  typedef logic [STEP_W-1:0] step_t;

  // microprogram addresses
  localparam step_t S_WAIT   = 4'd0;
  localparam step_t S_DISP   = 4'd1;
  localparam step_t S_SCAN   = 4'd2;
  localparam step_t S_MISS   = 4'd3;
  localparam step_t S_HIT    = 4'd4;
  localparam step_t S_APPEND = 4'd5;
  localparam step_t S_WRVAL  = 4'd6;
  localparam step_t S_FAIL   = 4'd7;
  localparam step_t S_HITVAL = 4'd8;
  localparam step_t S_RDIDX  = 4'd9;
  localparam step_t S_IDXRES = 4'd10;
  localparam step_t S_RDLAST = 4'd11;
  localparam step_t S_MOVE   = 4'd12;
  localparam step_t S_RESULT = 4'd13;

  // dispatch table selects, carried in the target field of a dispatch word
  localparam step_t D_CMD  = 4'd0;
  localparam step_t D_MISS = 4'd1;
  localparam step_t D_HIT  = 4'd2;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SCAN,
    OP_APPEND,
    OP_WRVAL,
    OP_FAIL,
    OP_HITVAL,
    OP_RDIDX,
    OP_IDXRES,
    OP_RDLAST,
    OP_MOVE,
    OP_RESULT
  } op_e;

  typedef enum logic [2:0] {
    J_NEXT,
    J_ALWAYS,
    J_WAIT_REQ,
    J_DISPATCH,
    J_SCAN,
    J_WAIT_OUT
  } jump_e;

  typedef struct packed {
    op_e   op;
    jump_e jump;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic             accept;
    logic             hit;
    logic             miss;
    logic             out_free;
    logic [CMD_W-1:0] cmd;
  } kvte_stat_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [31:0]      key;
    logic [31:0]      value;
    logic [IDX_W-1:0] index;
  } kvte_in_t;

  typedef struct packed {
    logic             ok;
    logic [31:0]      out_key;
    logic [31:0]      out_value;
    logic [CNT_W-1:0] entry_count;
    logic             is_empty;
  } kvte_out_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = '{op: OP_NOP, jump: J_ALWAYS, target: S_WAIT};
    case (step)
      S_WAIT:   w = '{op: OP_LOAD,   jump: J_WAIT_REQ, target: S_WAIT};
      S_DISP:   w = '{op: OP_NOP,    jump: J_DISPATCH, target: D_CMD};
      S_SCAN:   w = '{op: OP_SCAN,   jump: J_SCAN,     target: S_HIT};
      S_MISS:   w = '{op: OP_NOP,    jump: J_DISPATCH, target: D_MISS};
      S_HIT:    w = '{op: OP_NOP,    jump: J_DISPATCH, target: D_HIT};
      S_APPEND: w = '{op: OP_APPEND, jump: J_ALWAYS,   target: S_RESULT};
      S_WRVAL:  w = '{op: OP_WRVAL,  jump: J_ALWAYS,   target: S_RESULT};
      S_FAIL:   w = '{op: OP_FAIL,   jump: J_ALWAYS,   target: S_RESULT};
      S_HITVAL: w = '{op: OP_HITVAL, jump: J_ALWAYS,   target: S_RESULT};
      S_RDIDX:  w = '{op: OP_RDIDX,  jump: J_NEXT,     target: S_WAIT};
      S_IDXRES: w = '{op: OP_IDXRES, jump: J_ALWAYS,   target: S_RESULT};
      S_RDLAST: w = '{op: OP_RDLAST, jump: J_NEXT,     target: S_WAIT};
      S_MOVE:   w = '{op: OP_MOVE,   jump: J_NEXT,     target: S_WAIT};
      S_RESULT: w = '{op: OP_RESULT, jump: J_WAIT_OUT, target: S_WAIT};
      default:  w = '{op: OP_NOP,    jump: J_ALWAYS,   target: S_WAIT};
    endcase
    return w;
  endfunction

  function automatic step_t dispatch_step(input step_t tbl, input logic [CMD_W-1:0] cmd);
    step_t s;
    s = S_FAIL;
    case (tbl)
      D_CMD: begin
        case (cmd)
          CMD_INSERT, CMD_UPDATE, CMD_UPSERT,
          CMD_ERASE, CMD_LOOKUP:            s = S_SCAN;
          CMD_GETIDX:                       s = S_RDIDX;
          default:                          s = S_FAIL;
        endcase
      end
      D_MISS: begin
        case (cmd)
          CMD_INSERT, CMD_UPSERT: s = S_APPEND;
          default:                s = S_FAIL;
        endcase
      end
      D_HIT: begin
        case (cmd)
          CMD_UPDATE, CMD_UPSERT: s = S_WRVAL;
          CMD_ERASE:              s = S_RDLAST;
          CMD_LOOKUP:             s = S_HITVAL;
          default:                s = S_FAIL;
        endcase
      end
      default: s = S_FAIL;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/kvte_seq.sv
module kvte_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kvte_pkg::kvte_stat_t stat_i,
  output kvte_pkg::ucode_t    ctrl_o
);
  import kvte_pkg::*;

  step_t  step_q, step_d;
  ucode_t word;

  assign word   = ucode_rom(step_q);
  assign ctrl_o = word;

  always_comb begin
    step_d = step_q;
    case (word.jump)
      J_NEXT:     step_d = step_q + step_t'(1);
      J_ALWAYS:   step_d = word.target;
      J_WAIT_REQ: step_d = stat_i.accept ? step_q + step_t'(1) : step_q;
      J_DISPATCH: step_d = dispatch_step(word.target, stat_i.cmd);
      // stay while searching; a hit jumps, a miss falls through
      J_SCAN: begin
        if (stat_i.hit) begin
          step_d = word.target;
        end else if (stat_i.miss) begin
          step_d = step_q + step_t'(1);
        end
      end
      J_WAIT_OUT: step_d = stat_i.out_free ? word.target : step_q;
      default:    step_d = S_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// File: rtl/core/kvte_datapath.sv
module kvte_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  kvte_pkg::ucode_t             ctrl_i,
  output kvte_pkg::kvte_stat_t         stat_o,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  kvte_pkg::kvte_in_t           in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output kvte_pkg::kvte_out_t          out_rsp_o,
  input  logic                         cfg_we_i,
  input  logic [kvte_pkg::LIMIT_W-1:0] cfg_data_i
);
  import kvte_pkg::*;

  logic [ENTRY_W-1:0] mem [CAPACITY];

  logic [CMD_W-1:0]       cmd_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [IDX_W-1:0]       idx_q;
  logic [CNT_W-1:0]       ptr_q;
  logic                   rdv_q;
  logic [ADDR_W-1:0]      raddr_q;
  logic [ENTRY_W-1:0]     rdata_q;
  logic [ADDR_W-1:0]      slot_q;
  logic [VALUE_WIDTH-1:0] hit_val_q;
  logic                   ok_q;
  logic [KEY_WIDTH-1:0]   res_key_q;
  logic [VALUE_WIDTH-1:0] res_val_q;
  logic [CNT_W-1:0]       count_q;
  logic [LIMIT_W-1:0]     limit_q;
  kvte_out_t              out_q;
  logic                   out_valid_q;

  logic                   accept, out_free, hit, miss, can_add, idx_ok;
  logic [CNT_W-1:0]       lim, count_m1;
  logic                   re, we;
  logic [ADDR_W-1:0]      raddr, waddr;
  logic [ENTRY_W-1:0]     wdata;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;

  assign in_ready_o = (ctrl_i.op == OP_LOAD);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign rd_key   = rdata_q[ENTRY_W-1:VALUE_WIDTH];
  assign rd_val   = rdata_q[VALUE_WIDTH-1:0];
  assign lim      = (limit_q > CAP_CNT) ? CAP_CNT : limit_q;
  assign can_add  = count_q < lim;
  assign count_m1 = count_q - CNT_W'(1);
  assign idx_ok   = {1'b0, idx_q} < count_q;

  // one compare per cycle, on data read the cycle before
  assign hit  = (ctrl_i.op == OP_SCAN) && rdv_q && (rd_key == key_q);
  assign miss = (ctrl_i.op == OP_SCAN) && !rdv_q && (ptr_q >= count_q);

  assign stat_o = '{accept: accept, hit: hit, miss: miss, out_free: out_free, cmd: cmd_q};

  always_comb begin
    re    = 1'b0;
    raddr = ptr_q[ADDR_W-1:0];
    we    = 1'b0;
    waddr = slot_q;
    wdata = {key_q, val_q};
    case (ctrl_i.op)
      OP_SCAN:   re = ptr_q < count_q;
      OP_RDLAST: begin
        re    = 1'b1;
        raddr = count_m1[ADDR_W-1:0];
      end
      OP_RDIDX: begin
        re    = idx_ok;
        raddr = idx_q[ADDR_W-1:0];
      end
      OP_APPEND: begin
        we    = can_add;
        waddr = count_q[ADDR_W-1:0];
      end
      OP_WRVAL: we = 1'b1;
      OP_MOVE: begin
        we    = 1'b1;
        wdata = rdata_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_req_i.command;
      key_q <= in_req_i.key;
      val_q <= in_req_i.value;
      idx_q <= in_req_i.index;
    end
    if (re) begin
      raddr_q <= raddr;
    end
    if (hit) begin
      slot_q    <= raddr_q;
      hit_val_q <= rd_val;
    end
    case (ctrl_i.op)
      OP_APPEND: begin
        ok_q      <= can_add;
        res_key_q <= '0;
        res_val_q <= '0;
      end
      OP_WRVAL, OP_MOVE: begin
        ok_q      <= 1'b1;
        res_key_q <= '0;
        res_val_q <= '0;
      end
      OP_FAIL: begin
        ok_q      <= 1'b0;
        res_key_q <= '0;
        res_val_q <= '0;
      end
      OP_HITVAL: begin
        ok_q      <= 1'b1;
        res_key_q <= '0;
        res_val_q <= hit_val_q;
      end
      OP_RDIDX: ok_q <= idx_ok;
      OP_IDXRES: begin
        res_key_q <= ok_q ? rd_key : '0;
        res_val_q <= ok_q ? rd_val : '0;
      end
      default: ;
    endcase
    if ((ctrl_i.op == OP_RESULT) && out_free) begin
      out_q <= '{ok: ok_q, out_key: res_key_q, out_value: res_val_q,
                 entry_count: count_q, is_empty: (count_q == '0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      rdv_q       <= 1'b0;
      count_q     <= '0;
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (accept) begin
        ptr_q <= '0;
        rdv_q <= 1'b0;
      end else if (ctrl_i.op == OP_SCAN) begin
        rdv_q <= re;
        if (re) begin
          ptr_q <= ptr_q + CNT_W'(1);
        end
      end
      if ((ctrl_i.op == OP_APPEND) && can_add) begin
        count_q <= count_q + CNT_W'(1);
      end else if (ctrl_i.op == OP_MOVE) begin
        count_q <= count_m1;
      end
      if ((ctrl_i.op == OP_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// File: rtl/core/key_value_table_engine.sv
// Key-value table of up to 256 entries, searched one stored key per cycle through a
// single-read-port memory. A command that searches (insert, update, insert-or-update,
// erase, lookup) reads the stored keys in slot order and stops at the first hit; a miss
// reads all entry_count slots. Get-by-index reads its one slot and unused commands fail,
// neither with a scan. One request is in work at a time; the next request is taken as
// soon as the result is in the output register, whether or not it has been taken yet.
// The user must write the capacity limit through cfg_we_i/cfg_data_i only while the
// block is idle; the block itself does not enforce this. The limit in force is the
// smaller of it and 256. The memory has no reset and needs no clearing pass: only slots
// below the entry count are ever read.
module key_value_table_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  kvte_pkg::kvte_in_t           in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output kvte_pkg::kvte_out_t          out_rsp_o,
  input  logic                         cfg_we_i,
  input  logic [kvte_pkg::LIMIT_W-1:0] cfg_data_i
);
  import kvte_pkg::*;

  ucode_t     ctrl;
  kvte_stat_t stat;

  kvte_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  kvte_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  // one request in work at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in work");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.is_empty == (out_rsp_o.entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  a_key_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.out_key != '0 || out_rsp_o.out_value != '0)) |->
      out_rsp_o.ok)
    else $error("result data on a failed request");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.entry_count <= CAP_CNT))
    else $error("entry count beyond capacity");

endmodule

// File: bench/key_value_table_engine_test.sv
`timescale 1ns / 100ps

module key_value_table_engine_test;
  import kvte_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
  localparam int unsigned KEY_POOL = 12;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned SETTLE_CYCLES = 300;

  typedef struct {
    logic               cfg_row;
    logic [LIMIT_W-1:0] limit;
    kvte_in_t           req;
    logic               pinned;
    kvte_out_t          want;
  } script_row_t;

  logic               clk = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  kvte_in_t           in_req_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  kvte_out_t          out_rsp_o;
  logic               cfg_we_i = 1'b0;
  logic [LIMIT_W-1:0] cfg_data_i = '0;

  // shadow copy of the table, advanced on every accepted request
  logic [31:0]        shadow_keys [CAPACITY];
  logic [31:0]        shadow_vals [CAPACITY];
  int unsigned        shadow_count = 0;
  logic [LIMIT_W-1:0] shadow_limit = LIMIT_RESET;

  kvte_out_t          pending_rsp[$];
  kvte_out_t          rsp_want;
  script_row_t        script[$];
  logic [31:0]        key_pool [KEY_POOL];

  // directed rows may carry a typed-in response for the request being driven
  logic               pin_active = 1'b0;
  kvte_out_t          pin_rsp = '0;

  int unsigned        send_gap_pct = 0;
  int unsigned        ready_stall_pct = 0;
  int unsigned        errors = 0;
  int unsigned        cycle_count = 0;

  key_value_table_engine dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic kvte_out_t apply_request(kvte_in_t r);
    kvte_out_t   o;
    int          slot;
    int unsigned lim;
    int unsigned i;
    o = '0;
    slot = -1;
    lim = (shadow_limit > CAPACITY) ? CAPACITY : shadow_limit;
    for (i = 0; i < shadow_count; i++) begin
      if (slot < 0 && shadow_keys[i] == r.key) slot = int'(i);
    end
    case (r.command)
      CMD_INSERT: begin
        if (slot < 0 && shadow_count < lim) begin
          shadow_keys[shadow_count] = r.key;
          shadow_vals[shadow_count] = r.value;
          shadow_count++;
          o.ok = 1'b1;
        end
      end
      CMD_UPDATE: begin
        if (slot >= 0) begin
          shadow_vals[slot] = r.value;
          o.ok = 1'b1;
        end
      end
      CMD_UPSERT: begin
        if (slot >= 0) begin
          shadow_vals[slot] = r.value;
          o.ok = 1'b1;
        end else if (shadow_count < lim) begin
          shadow_keys[shadow_count] = r.key;
          shadow_vals[shadow_count] = r.value;
          shadow_count++;
          o.ok = 1'b1;
        end
      end
      CMD_ERASE: begin
        // last entry fills the hole
        if (slot >= 0) begin
          shadow_keys[slot] = shadow_keys[shadow_count - 1];
          shadow_vals[slot] = shadow_vals[shadow_count - 1];
          shadow_count--;
          o.ok = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        if (slot >= 0) begin
          o.ok = 1'b1;
          o.out_value = shadow_vals[slot];
        end
      end
      CMD_GETIDX: begin
        if (r.index < shadow_count) begin
          o.ok = 1'b1;
          o.out_key = shadow_keys[r.index];
          o.out_value = shadow_vals[r.index];
        end
      end
      default: begin
      end
    endcase
    o.entry_count = CNT_W'(shadow_count);
    o.is_empty = (shadow_count == 0);
    return o;
  endfunction

  task automatic check_field(input string label, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_ni) begin
      if (cfg_we_i) shadow_limit = cfg_data_i;
      if (out_valid_o && out_ready_i) begin
        if (pending_rsp.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected response, expected none, got %h", $time, out_rsp_o);
        end else begin
          rsp_want = pending_rsp.pop_front();
          check_field("ok", 32'(rsp_want.ok), 32'(out_rsp_o.ok));
          check_field("out_key", rsp_want.out_key, out_rsp_o.out_key);
          check_field("out_value", rsp_want.out_value, out_rsp_o.out_value);
          check_field("entry_count", 32'(rsp_want.entry_count), 32'(out_rsp_o.entry_count));
          check_field("is_empty", 32'(rsp_want.is_empty), 32'(out_rsp_o.is_empty));
        end
      end
      if (in_valid_i && in_ready_o) begin
        rsp_want = apply_request(in_req_i);
        pending_rsp.push_back(pin_active ? pin_rsp : rsp_want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready_i <= ($urandom_range(0, 99) >= ready_stall_pct);
  end

  function automatic kvte_out_t mk_rsp(logic hit, logic [31:0] k, logic [31:0] v,
                                       int unsigned n);
    return '{ok: hit, out_key: k, out_value: v, entry_count: CNT_W'(n), is_empty: (n == 0)};
  endfunction

  function automatic void add_cfg(logic [LIMIT_W-1:0] lim);
    script.push_back('{cfg_row: 1'b1, limit: lim, req: '0, pinned: 1'b0, want: '0});
  endfunction

  function automatic void add_req(logic [CMD_W-1:0] c, logic [31:0] k, logic [31:0] v,
                                  logic [IDX_W-1:0] idx, logic pinned, kvte_out_t want);
    script.push_back('{cfg_row: 1'b0, limit: '0,
                       req: '{command: c, key: k, value: v, index: idx},
                       pinned: pinned, want: want});
  endfunction

  function automatic kvte_in_t random_request(int unsigned ins_pct, int unsigned fresh_pct);
    kvte_in_t    r;
    int unsigned roll;
    int unsigned top;
    if ($urandom_range(0, 99) < ins_pct) begin
      r.command = CMD_INSERT;
    end else begin
      case ($urandom_range(0, 15))
        0, 1, 2:    r.command = CMD_UPSERT;
        3, 4:       r.command = CMD_UPDATE;
        5, 6, 7:    r.command = CMD_ERASE;
        8, 9, 10:   r.command = CMD_LOOKUP;
        11, 12, 13: r.command = CMD_GETIDX;
        14:         r.command = CMD_SPARE6;
        default:    r.command = CMD_SPARE7;
      endcase
    end
    // mix of new keys, a small recurring set, and keys known to be stored
    roll = $urandom_range(0, 99);
    if (roll < fresh_pct) begin
      r.key = $urandom;
    end else if (shadow_count == 0 || roll < fresh_pct + (100 - fresh_pct) / 2) begin
      r.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
    end else begin
      r.key = shadow_keys[$urandom_range(0, shadow_count - 1)];
    end
    r.value = $urandom;
    top = (shadow_count < 255) ? shadow_count + 1 : 255;
    r.index = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 255)) :
                                            IDX_W'($urandom_range(0, top));
    return r;
  endfunction

  // entered right after a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input kvte_in_t r, input logic pinned, input kvte_out_t want);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk);
    end
    in_req_i <= r;
    in_valid_i <= 1'b1;
    pin_active = pinned;
    pin_rsp = want;
    do @(posedge clk); while (!in_ready_o);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] lim);
    drain();
    cfg_data_i <= lim;
    cfg_we_i <= 1'b1;
    @(negedge clk);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int unsigned items,
                           input int unsigned gap, input int unsigned stall,
                           input int unsigned ins_pct, input int unsigned fresh_pct);
    int unsigned n;
    write_limit(lim);
    send_gap_pct = gap;
    ready_stall_pct = stall;
    for (n = 0; n < items; n++) send_request(random_request(ins_pct, fresh_pct), 1'b0, '0);
  endtask

  initial begin
    int unsigned n;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (n = 2; n < KEY_POOL; n++) key_pool[n] = $urandom;

    // empty table, unused commands, extremes of key and value
    add_req(CMD_LOOKUP, 32'h0, 32'h0, 8'h00, 1'b1, mk_rsp(1'b0, 32'h0, 32'h0, 0));
    add_req(CMD_GETIDX, 32'h0, 32'h0, 8'h00, 1'b1, mk_rsp(1'b0, 32'h0, 32'h0, 0));
    add_req(CMD_ERASE, 32'h0, 32'h0, 8'h00, 1'b1, mk_rsp(1'b0, 32'h0, 32'h0, 0));
    add_req(CMD_UPDATE, '1, '1, 8'h00, 1'b1, mk_rsp(1'b0, 32'h0, 32'h0, 0));
    add_req(CMD_SPARE6, '1, '1, 8'hFF, 1'b1, mk_rsp(1'b0, 32'h0, 32'h0, 0));
    add_req(CMD_SPARE7, '1, '1, 8'hFF, 1'b1, mk_rsp(1'b0, 32'h0, 32'h0, 0));
    add_req(CMD_INSERT, '1, '1, 8'hFF, 1'b1, mk_rsp(1'b1, 32'h0, 32'h0, 1));
    add_req(CMD_INSERT, 32'h0, 32'h0, 8'h00, 1'b1, mk_rsp(1'b1, 32'h0, 32'h0, 2));
    add_req(CMD_INSERT, '1, 32'h1, 8'h00, 1'b1, mk_rsp(1'b0, 32'h0, 32'h0, 2));
    add_req(CMD_LOOKUP, '1, 32'h0, 8'h00, 1'b1, mk_rsp(1'b1, 32'h0, '1, 2));
    add_req(CMD_GETIDX, 32'h0, 32'h0, 8'h00, 1'b1, mk_rsp(1'b1, '1, '1, 2));
    add_req(CMD_GETIDX, 32'h0, 32'h0, 8'h01, 1'b1, mk_rsp(1'b1, 32'h0, 32'h0, 2));
    add_req(CMD_GETIDX, 32'h0, 32'h0, 8'h02, 1'b1, mk_rsp(1'b0, 32'h0, 32'h0, 2));
    add_req(CMD_GETIDX, 32'h0, 32'h0, 8'hFF, 1'b1, mk_rsp(1'b0, 32'h0, 32'h0, 2));
    add_req(CMD_UPSERT, 32'h0, 32'hA5A5_A5A5, 8'h00, 1'b0, '0);
    add_req(CMD_UPSERT, 32'h1234_5678, 32'h0F0F_0F0F, 8'h00, 1'b0, '0);
    add_req(CMD_UPDATE, 32'h0, 32'h5A5A_5A5A, 8'h00, 1'b0, '0);
    add_req(CMD_ERASE, '1, 32'h0, 8'h00, 1'b0, '0);
    add_req(CMD_GETIDX, 32'h0, 32'h0, 8'h00, 1'b0, '0);
    // zero limit with entries held: no insert, but present keys still update
    add_cfg(9'd0);
    add_req(CMD_INSERT, 32'h7, 32'h7, 8'h00, 1'b1, mk_rsp(1'b0, 32'h0, 32'h0, 2));
    add_req(CMD_UPSERT, 32'h0, 32'h3, 8'h00, 1'b0, '0);
    add_req(CMD_UPSERT, 32'h99, 32'h3, 8'h00, 1'b0, '0);
    add_req(CMD_ERASE, 32'h0, 32'h0, 8'h00, 1'b0, '0);
    add_req(CMD_ERASE, 32'h1234_5678, 32'h0, 8'h00, 1'b0, '0);
    add_req(CMD_INSERT, 32'h5, 32'h5, 8'h00, 1'b1, mk_rsp(1'b0, 32'h0, 32'h0, 0));
    add_cfg(9'd1);
    add_req(CMD_INSERT, 32'h8, 32'h8, 8'h00, 1'b1, mk_rsp(1'b1, 32'h0, 32'h0, 1));
    add_req(CMD_INSERT, 32'h9, 32'h9, 8'h00, 1'b1, mk_rsp(1'b0, 32'h0, 32'h0, 1));

    repeat (7) @(negedge clk);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].cfg_row) begin
        write_limit(script[i].limit);
      end else begin
        send_request(script[i].req, script[i].pinned, script[i].want);
      end
    end

    run_phase(9'd16, 100, 0, 0, 25, 10);
    run_phase(9'd4, 100, 82, 0, 25, 10);
    run_phase(9'd1, 80, 0, 82, 25, 10);

    // fill to the full 256 entries, then keep working on a full table
    write_limit(9'd511);
    send_gap_pct = 29;
    ready_stall_pct = 29;
    while (shadow_count < CAPACITY) send_request(random_request(88, 90), 1'b0, '0);
    for (n = 0; n < 20; n++) send_request(random_request(40, 20), 1'b0, '0);

    run_phase(9'd0, 60, 0, 82, 20, 10);
    run_phase(9'd256, 60, 0, 0, 30, 20);

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
